>>> hw/rtl/gbnms_pkg.sv
package gbnms_pkg;

  localparam int MAX_KEPT   = 64;
  localparam int COORD_BITS = 12;

  localparam int SCORE_BITS = 16;
  localparam int CLASS_BITS = 8;
  localparam int SLOT_BITS  = 6;
  localparam int THR_BITS   = 9;
  localparam int IOU_FRAC   = 8;

  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(128);

  localparam int IDX_W  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W  = $clog2(MAX_KEPT + 1);
  localparam int EDGE_W = COORD_BITS + 1;
  localparam int AREA_W = 2 * COORD_BITS;
  localparam int UNI_W  = AREA_W + 1;
  localparam int PROD_W = THR_BITS + UNI_W;

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [EDGE_W-1:0]     edge_t;
  typedef logic [AREA_W-1:0]     area_t;

  // One entry of the kept table.
  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t width;
    coord_t height;
  } box_t;

  // A classified box waiting in the queue.
  typedef struct packed {
    logic                  frame_start;
    box_t                  box;
    edge_t                 right;
    edge_t                 bottom;
    area_t                 area;
    logic [SCORE_BITS-1:0] score;
    logic [CLASS_BITS-1:0] cls;
  } job_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
    logic res_hit;
  } cmp_status_t;

endpackage

>>> hw/rtl/gbnms_front.sv
module gbnms_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            frame_start,
  input  gbnms_pkg::coord_t               box_left,
  input  gbnms_pkg::coord_t               box_top,
  input  gbnms_pkg::coord_t               box_width,
  input  gbnms_pkg::coord_t               box_height,
  input  logic [gbnms_pkg::SCORE_BITS-1:0] box_score,
  input  logic [gbnms_pkg::CLASS_BITS-1:0] box_class,
  output logic                            q_valid,
  input  logic                            q_pop,
  output gbnms_pkg::job_t                 q_job
);

  gbnms_pkg::job_t                 queue [gbnms_pkg::Q_DEPTH];
  logic [gbnms_pkg::QPTR_W-1:0]    wr_ptr;
  logic [gbnms_pkg::QPTR_W-1:0]    rd_ptr;
  logic [gbnms_pkg::QCNT_W-1:0]    q_cnt;
  gbnms_pkg::job_t                 job_in;
  logic                            push;
  logic                            pop;

  // Edges and area of the incoming box are worked out once here, so the
  // back only has to handle the stored box on each compare.
  always_comb begin
    job_in.frame_start = frame_start;
    job_in.box.left    = box_left;
    job_in.box.top     = box_top;
    job_in.box.width   = box_width;
    job_in.box.height  = box_height;
    job_in.right       = gbnms_pkg::EDGE_W'(box_left) + gbnms_pkg::EDGE_W'(box_width);
    job_in.bottom      = gbnms_pkg::EDGE_W'(box_top) + gbnms_pkg::EDGE_W'(box_height);
    job_in.area        = gbnms_pkg::AREA_W'(box_width) * gbnms_pkg::AREA_W'(box_height);
    job_in.score       = box_score;
    job_in.cls         = box_class;
  end

  assign in_stall = (q_cnt == gbnms_pkg::QCNT_W'(gbnms_pkg::Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (q_cnt != '0);
  assign pop      = q_pop && q_valid;
  assign q_job    = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_cnt  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == gbnms_pkg::QPTR_W'(gbnms_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == gbnms_pkg::QPTR_W'(gbnms_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        q_cnt <= q_cnt + 1'b1;
      end else if (pop && !push) begin
        q_cnt <= q_cnt - 1'b1;
      end
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

>>> hw/rtl/gbnms_cmp.sv
module gbnms_cmp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmp_valid,
  input  gbnms_pkg::box_t                   kept_box,
  input  gbnms_pkg::job_t                   cur,
  input  logic [gbnms_pkg::THR_BITS-1:0]    thr,
  output gbnms_pkg::cmp_status_t            status
);

  // Stage 1: overlap extents and area of the stored box.
  logic                      s1_valid;
  logic                      s1_ovl;
  gbnms_pkg::coord_t         s1_dx;
  gbnms_pkg::coord_t         s1_dy;
  gbnms_pkg::area_t          s1_area;
  // Stage 2: intersection.
  logic                      s2_valid;
  logic                      s2_ovl;
  gbnms_pkg::area_t          s2_inter;
  gbnms_pkg::area_t          s2_area;
  // Stage 3: union.
  logic                      s3_valid;
  logic                      s3_ovl;
  gbnms_pkg::area_t          s3_inter;
  logic [gbnms_pkg::UNI_W-1:0] s3_uni;
  // Stage 4: threshold test.
  logic                      res_valid;
  logic                      res_hit;

  gbnms_pkg::edge_t          k_left;
  gbnms_pkg::edge_t          k_top;
  gbnms_pkg::edge_t          k_right;
  gbnms_pkg::edge_t          k_bottom;
  gbnms_pkg::edge_t          lo_x;
  gbnms_pkg::edge_t          hi_x;
  gbnms_pkg::edge_t          lo_y;
  gbnms_pkg::edge_t          hi_y;
  gbnms_pkg::edge_t          dx_full;
  gbnms_pkg::edge_t          dy_full;
  logic [gbnms_pkg::PROD_W-1:0] lhs;
  logic [gbnms_pkg::PROD_W-1:0] rhs;

  always_comb begin
    k_left   = gbnms_pkg::EDGE_W'(kept_box.left);
    k_top    = gbnms_pkg::EDGE_W'(kept_box.top);
    k_right  = k_left + gbnms_pkg::EDGE_W'(kept_box.width);
    k_bottom = k_top + gbnms_pkg::EDGE_W'(kept_box.height);
    lo_x     = (gbnms_pkg::EDGE_W'(cur.box.left) > k_left) ?
               gbnms_pkg::EDGE_W'(cur.box.left) : k_left;
    hi_x     = (cur.right < k_right) ? cur.right : k_right;
    lo_y     = (gbnms_pkg::EDGE_W'(cur.box.top) > k_top) ?
               gbnms_pkg::EDGE_W'(cur.box.top) : k_top;
    hi_y     = (cur.bottom < k_bottom) ? cur.bottom : k_bottom;
    dx_full  = hi_x - lo_x;
    dy_full  = hi_y - lo_y;
  end

  // When the boxes overlap, each extent is at most the smaller side, so it
  // fits in a coordinate.
  always_ff @(posedge clk) begin
    s1_ovl   <= (lo_x < hi_x) && (lo_y < hi_y);
    s1_dx    <= dx_full[gbnms_pkg::COORD_BITS-1:0];
    s1_dy    <= dy_full[gbnms_pkg::COORD_BITS-1:0];
    s1_area  <= gbnms_pkg::AREA_W'(kept_box.width) * gbnms_pkg::AREA_W'(kept_box.height);
    s2_ovl   <= s1_ovl;
    s2_inter <= gbnms_pkg::AREA_W'(s1_dx) * gbnms_pkg::AREA_W'(s1_dy);
    s2_area  <= s1_area;
    s3_ovl   <= s2_ovl;
    s3_inter <= s2_inter;
    s3_uni   <= gbnms_pkg::UNI_W'(cur.area) + gbnms_pkg::UNI_W'(s2_area)
                - gbnms_pkg::UNI_W'(s2_inter);
    res_hit  <= s3_ovl ? (lhs >= rhs) : (thr == '0);
  end

  assign lhs = gbnms_pkg::PROD_W'(s3_inter) << gbnms_pkg::IOU_FRAC;
  assign rhs = gbnms_pkg::PROD_W'(thr) * gbnms_pkg::PROD_W'(s3_uni);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      s1_valid  <= cmp_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      res_valid <= s3_valid;
    end
  end

  assign status.busy      = s1_valid || s2_valid || s3_valid || res_valid;
  assign status.res_valid = res_valid;
  assign status.res_hit   = res_hit;

endmodule

>>> hw/rtl/gbnms_back.sv
module gbnms_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gbnms_pkg::THR_BITS-1:0]   cfg_wdata,
  input  logic                             q_valid,
  output logic                             q_pop,
  input  gbnms_pkg::job_t                  q_job,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             kept,
  output logic                             table_overflow,
  output logic [gbnms_pkg::SLOT_BITS-1:0]  kept_slot,
  output gbnms_pkg::coord_t                out_left,
  output gbnms_pkg::coord_t                out_top,
  output gbnms_pkg::coord_t                out_width,
  output gbnms_pkg::coord_t                out_height,
  output logic [gbnms_pkg::SCORE_BITS-1:0] out_score,
  output logic [gbnms_pkg::CLASS_BITS-1:0] out_class
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]                      state;
  logic [gbnms_pkg::CNT_W-1:0]     cnt;
  logic [gbnms_pkg::CNT_W-1:0]     eff_cnt;
  logic [gbnms_pkg::IDX_W-1:0]     rd_idx;
  logic                            rd_en;
  logic                            rd_valid;
  logic                            rd_last;
  gbnms_pkg::box_t                 rd_data;
  gbnms_pkg::box_t                 kept_mem [gbnms_pkg::MAX_KEPT];
  logic                            mem_we;
  logic                            hit;
  logic                            room;
  logic                            out_free;
  logic                            store;
  logic [gbnms_pkg::THR_BITS-1:0]  thr;
  gbnms_pkg::job_t                 cur;
  gbnms_pkg::cmp_status_t          cmp_st;

  assign eff_cnt  = q_job.frame_start ? '0 : cnt;
  assign rd_en    = (state == ST_SCAN);
  assign rd_last  = (gbnms_pkg::CNT_W'(rd_idx) + 1'b1 == cnt);
  assign room     = (cnt < gbnms_pkg::CNT_W'(gbnms_pkg::MAX_KEPT));
  assign out_free = !out_valid || !out_stall;
  assign store    = !hit && room;
  assign mem_we   = (state == ST_FINISH) && out_free && store;
  assign q_pop    = (state == ST_IDLE) && q_valid;

  // Kept table: one read port for the scan, one write when a box is kept.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      kept_mem[cnt[gbnms_pkg::IDX_W-1:0]] <= cur.box;
    end
    if (rd_en) begin
      rd_data <= kept_mem[rd_idx];
    end
  end

  gbnms_cmp u_cmp (
    .clk       (clk),
    .rst       (rst),
    .cmp_valid (rd_valid),
    .kept_box  (rd_data),
    .cur       (cur),
    .thr       (thr),
    .status    (cmp_st)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
    if ((state == ST_FINISH) && out_free) begin
      kept           <= store;
      table_overflow <= !hit && !room;
      kept_slot      <= store ? gbnms_pkg::SLOT_BITS'(cnt) : '0;
      out_left       <= cur.box.left;
      out_top        <= cur.box.top;
      out_width      <= cur.box.width;
      out_height     <= cur.box.height;
      out_score      <= cur.score;
      out_class      <= cur.cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rd_idx    <= '0;
      rd_valid  <= 1'b0;
      hit       <= 1'b0;
      thr       <= gbnms_pkg::THR_RESET;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      if (cfg_we) begin
        thr <= cfg_wdata;
      end
      if ((state == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmp_st.res_valid && cmp_st.res_hit) begin
        hit <= 1'b1;
      end else if ((state == ST_IDLE) && q_valid) begin
        hit <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cnt    <= eff_cnt;
            rd_idx <= '0;
            state  <= (eff_cnt == '0) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_idx <= rd_idx + 1'b1;
          if (rd_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // The last result has reached the hit flag once nothing is in flight.
          if (!rd_valid && !cmp_st.busy) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            if (store) begin
              cnt <= cnt + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (cnt < gbnms_pkg::CNT_W'(gbnms_pkg::MAX_KEPT)))
    else $error("kept table written beyond its depth");

  a_read_below_count: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (gbnms_pkg::CNT_W'(rd_idx) < cnt))
    else $error("scan read an entry above the kept count");

  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(kept && table_overflow))
    else $error("result both kept and overflowed");

  a_no_finish_in_flight: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> (!rd_valid && !cmp_st.busy))
    else $error("result produced while compares were still in flight");

endmodule

>>> hw/rtl/greedy_box_nms_filter_unit.sv
// Channel  | handshake                   | payload
// ---------+-----------------------------+----------------------------------------------
// input    | in_valid / in_stall         | frame_start, box_left/top/width/height,
//          |                             | box_score, box_class
// result   | out_valid / out_stall       | kept, table_overflow, kept_slot, out_left/top/
//          |                             | width/height, out_score, out_class
// config   | cfg_we (no wait)            | cfg_wdata = iou_threshold
//
// A box is compared with every entry kept before it; a box with nothing kept before it skips the scan.
// The scan reads one kept-table entry per cycle through the table's single read port,
// followed by the fill and drain of the four-stage compare pipeline.
// Reset clears the queue, the kept count and the result valid flag and sets the threshold
// to 128; table contents are not cleared, only entries below the count are ever read.
// A two-entry queue keeps taking boxes while the back end scans or a result is stalled.
module greedy_box_nms_filter_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gbnms_pkg::THR_BITS-1:0]   cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             frame_start,
  input  gbnms_pkg::coord_t                box_left,
  input  gbnms_pkg::coord_t                box_top,
  input  gbnms_pkg::coord_t                box_width,
  input  gbnms_pkg::coord_t                box_height,
  input  logic [gbnms_pkg::SCORE_BITS-1:0] box_score,
  input  logic [gbnms_pkg::CLASS_BITS-1:0] box_class,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             kept,
  output logic                             table_overflow,
  output logic [gbnms_pkg::SLOT_BITS-1:0]  kept_slot,
  output gbnms_pkg::coord_t                out_left,
  output gbnms_pkg::coord_t                out_top,
  output gbnms_pkg::coord_t                out_width,
  output gbnms_pkg::coord_t                out_height,
  output logic [gbnms_pkg::SCORE_BITS-1:0] out_score,
  output logic [gbnms_pkg::CLASS_BITS-1:0] out_class
);

  logic            q_valid;
  logic            q_pop;
  gbnms_pkg::job_t q_job;

  gbnms_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .frame_start (frame_start),
    .box_left    (box_left),
    .box_top     (box_top),
    .box_width   (box_width),
    .box_height  (box_height),
    .box_score   (box_score),
    .box_class   (box_class),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_job       (q_job)
  );

  gbnms_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_job          (q_job),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kept           (kept),
    .table_overflow (table_overflow),
    .kept_slot      (kept_slot),
    .out_left       (out_left),
    .out_top        (out_top),
    .out_width      (out_width),
    .out_height     (out_height),
    .out_score      (out_score),
    .out_class      (out_class)
  );

endmodule
